>>> src/hsv_to_rgb_converter_assert.svh
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_assert
// Assertion macros shared by the color conversion block.
// ----------------------------------------------------------------------------
// Each macro takes a label, the clock, the reset and the two sides of the property.
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

// Same-cycle implication.
`define HSV_ASSERT_IMP(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// Next-cycle implication.
`define HSV_ASSERT_NXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

>>> src/hsv_pkg.sv
// ----------------------------------------------------------------------------
// hsv_pkg
// Types and constants for the integer HSV to RGB converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv_pkg;

   localparam int CHAN_W        = 8;
   localparam int HUE_SPAN      = 43;
   localparam int FRAC_SCALE    = 6;
   localparam int FULL_LEVEL    = 255;
   localparam int PRODUCT_SHIFT = 8;
   localparam int REGION_W      = 3;

   typedef logic [CHAN_W-1:0] chan_type;

   // Six hue regions around the wheel
   typedef enum logic [REGION_W-1:0] {
      REGION_RED_YEL = 3'd0,
      REGION_YEL_GRN = 3'd1,
      REGION_GRN_CYN = 3'd2,
      REGION_CYN_BLU = 3'd3,
      REGION_BLU_MAG = 3'd4,
      REGION_MAG_RED = 3'd5
   } region_type;

   // Region and scaled fraction of one hue
   typedef struct packed {
      region_type region;
      chan_type   frac;
   } hue_split_type;

endpackage

`default_nettype wire

>>> src/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Integer 8-bit HSV to RGB conversion in a four-stage pipeline.
// ----------------------------------------------------------------------------
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  request | req_valid, req_stall, req_hue/saturation/    | in
//          | brightness                                   |
//  response| rsp_valid, rsp_stall, rsp_red/green/blue     | out
//
//  One transaction per clock sustained while the response is not stalled; each
//  request passes through the four register stages in turn to its response.
//  Stages: region split, first products, second products, channel routing.
//  A stall on a held response freezes every stage; req_stall follows it at once.
//  Synchronous active-high reset clears the valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hsv_to_rgb_converter_assert.svh"

module hsv_to_rgb_converter (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire hsv_pkg::chan_type req_hue,
   input  wire hsv_pkg::chan_type req_saturation,
   input  wire hsv_pkg::chan_type req_brightness,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output hsv_pkg::chan_type   rsp_red,
   output hsv_pkg::chan_type   rsp_green,
   output hsv_pkg::chan_type   rsp_blue
);
   import hsv_pkg::*;

   localparam chan_type FULL = chan_type'(FULL_LEVEL);

   logic          advance;
   hue_split_type split;

   // stage 1
   logic          s1_valid_ff;
   hue_split_type s1_split_ff;
   chan_type      s1_sat_ff, s1_val_ff;

   // stage 2
   logic          s2_valid_ff;
   region_type    s2_region_ff;
   chan_type      s2_val_ff, s2_lo_ff, s2_sf_ff, s2_sr_ff;
   logic [2*CHAN_W-1:0] s2_lo_in, s2_sf_in, s2_sr_in;

   // stage 3
   logic          s3_valid_ff;
   region_type    s3_region_ff;
   chan_type      s3_val_ff, s3_lo_ff, s3_fall_ff, s3_rise_ff;
   logic [2*CHAN_W-1:0] s3_fall_in, s3_rise_in;

   // stage 4 (response register)
   logic          rsp_valid_ff;
   chan_type      red_ff, green_ff, blue_ff;
   chan_type      red_in, green_in, blue_in;

   // Advance the whole pipe unless the held response is stalled
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   hsv_region u_region (
      .hue   (req_hue),
      .split (split)
   );

   // Valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   // First products: low level and saturation-weighted fractions
   assign s2_lo_in = (2*CHAN_W)'(s1_val_ff) * (2*CHAN_W)'(FULL - s1_sat_ff);
   assign s2_sf_in = (2*CHAN_W)'(s1_sat_ff) * (2*CHAN_W)'(s1_split_ff.frac);
   assign s2_sr_in = (2*CHAN_W)'(s1_sat_ff) * (2*CHAN_W)'(FULL - s1_split_ff.frac);

   // Second products: falling and rising levels
   assign s3_fall_in = (2*CHAN_W)'(s2_val_ff) * (2*CHAN_W)'(FULL - s2_sf_ff);
   assign s3_rise_in = (2*CHAN_W)'(s2_val_ff) * (2*CHAN_W)'(FULL - s2_sr_ff);

   // Route levels to the channels by region
   always_comb begin
      unique case (s3_region_ff)
         REGION_RED_YEL: begin
            red_in = s3_val_ff;  green_in = s3_rise_ff; blue_in = s3_lo_ff;
         end
         REGION_YEL_GRN: begin
            red_in = s3_fall_ff; green_in = s3_val_ff;  blue_in = s3_lo_ff;
         end
         REGION_GRN_CYN: begin
            red_in = s3_lo_ff;   green_in = s3_val_ff;  blue_in = s3_rise_ff;
         end
         REGION_CYN_BLU: begin
            red_in = s3_lo_ff;   green_in = s3_fall_ff; blue_in = s3_val_ff;
         end
         REGION_BLU_MAG: begin
            red_in = s3_rise_ff; green_in = s3_lo_ff;   blue_in = s3_val_ff;
         end
         default: begin
            red_in = s3_val_ff;  green_in = s3_lo_ff;   blue_in = s3_fall_ff;
         end
      endcase
   end

   // Payload registers, held while stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_split_ff  <= split;
         s1_sat_ff    <= req_saturation;
         s1_val_ff    <= req_brightness;

         s2_region_ff <= s1_split_ff.region;
         s2_val_ff    <= s1_val_ff;
         s2_lo_ff     <= s2_lo_in[PRODUCT_SHIFT +: CHAN_W];
         s2_sf_ff     <= s2_sf_in[PRODUCT_SHIFT +: CHAN_W];
         s2_sr_ff     <= s2_sr_in[PRODUCT_SHIFT +: CHAN_W];

         s3_region_ff <= s2_region_ff;
         s3_val_ff    <= s2_val_ff;
         s3_lo_ff     <= s2_lo_ff;
         s3_fall_ff   <= s3_fall_in[PRODUCT_SHIFT +: CHAN_W];
         s3_rise_ff   <= s3_rise_in[PRODUCT_SHIFT +: CHAN_W];

         red_ff       <= red_in;
         green_ff     <= green_in;
         blue_ff      <= blue_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

   // An accepted transaction lands in the first stage
   `HSV_ASSERT_NXT(a_accept_enters, clock, reset, req_valid && !req_stall, s1_valid_ff)

   // A stall freezes the inner valid bits
   `HSV_ASSERT_NXT(a_stall_freezes, clock, reset, !advance,
                   $stable(s2_valid_ff) && $stable(s3_valid_ff))

   // The region split never yields an unused code
   `HSV_ASSERT_IMP(a_region_range, clock, reset, s1_valid_ff,
                   s1_split_ff.region <= REGION_MAG_RED)

endmodule

`default_nettype wire

>>> src/hsv_region.sv
// ----------------------------------------------------------------------------
// hsv_region
// Splits a hue into its region (hue / 43, with the top hues in the last
// region) and the remainder within the region scaled by 6.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_region (
   input  wire hsv_pkg::chan_type      hue,
   output hsv_pkg::hue_split_type      split
);
   import hsv_pkg::*;

   localparam chan_type EDGE_1 = chan_type'(HUE_SPAN * 1);
   localparam chan_type EDGE_2 = chan_type'(HUE_SPAN * 2);
   localparam chan_type EDGE_3 = chan_type'(HUE_SPAN * 3);
   localparam chan_type EDGE_4 = chan_type'(HUE_SPAN * 4);
   localparam chan_type EDGE_5 = chan_type'(HUE_SPAN * 5);

   region_type          region;
   chan_type            base;
   chan_type            rem;
   logic [CHAN_W+2:0]   scaled;

   // Divide by the region span through threshold compares
   always_comb begin
      priority if (hue >= EDGE_5) begin
         region = REGION_MAG_RED;
         base   = EDGE_5;
      end else if (hue >= EDGE_4) begin
         region = REGION_BLU_MAG;
         base   = EDGE_4;
      end else if (hue >= EDGE_3) begin
         region = REGION_CYN_BLU;
         base   = EDGE_3;
      end else if (hue >= EDGE_2) begin
         region = REGION_GRN_CYN;
         base   = EDGE_2;
      end else if (hue >= EDGE_1) begin
         region = REGION_YEL_GRN;
         base   = EDGE_1;
      end else begin
         region = REGION_RED_YEL;
         base   = '0;
      end
   end

   // Scale the remainder; keep the low channel bits
   assign rem          = hue - base;
   assign scaled       = (CHAN_W+3)'(rem) * (CHAN_W+3)'(FRAC_SCALE);
   assign split.region = region;
   assign split.frac   = scaled[CHAN_W-1:0];

endmodule

`default_nettype wire
